// ===== sv/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions of the max-heap priority queue
// Operation codes, status codes and the control word that the top level
// broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int STATUS_WIDTH = 2;

   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // One-cycle command seen by all cells at once.
   typedef struct packed {
      logic insert;
      logic extract;
   } mhpq_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/mhpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted key chain
// Holds one key. On insert it keeps its key, takes the new key or takes its
// left neighbor's key; on extract it takes its right neighbor's key.
// ----------------------------------------------------------------------------
module mhpq_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int CNT_WIDTH = 7,
   parameter int INDEX     = 0
) (
   input  wire                         clock,
   input  wire mhpq_pkg::mhpq_ctrl_type ctrl,
   input  wire signed [KEY_WIDTH-1:0]  new_key,
   input  wire        [CNT_WIDTH-1:0]  count,
   input  wire signed [KEY_WIDTH-1:0]  left_key,
   input  wire                         left_stays,
   input  wire signed [KEY_WIDTH-1:0]  right_key,
   output logic signed [KEY_WIDTH-1:0] key,
   output logic                        stays
);
   import mhpq_pkg::*;

   logic signed [KEY_WIDTH-1:0] key_ff;
   logic signed [KEY_WIDTH-1:0] key_in;
   logic                        occupied;

   assign occupied = count > CNT_WIDTH'(INDEX);
   // The occupied cells are sorted largest first, so this is a prefix.
   assign stays    = occupied && (key_ff >= new_key);

   always_comb begin
      key_in = key_ff;
      if (ctrl.insert) begin
         if (!stays) begin
            key_in = left_stays ? new_key : left_key;
         end
      end else if (ctrl.extract) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule
`default_nettype wire

// ===== sv/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue: fixed-capacity priority queue of signed keys
// Inserts keys and extracts the largest one, reporting the key count after
// every operation, with a chain of sorted storage cells.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake           fields
//   req       in          req_valid/stall     req_func, req_key_in
//   rsp       out         rsp_valid/stall     rsp_key_out, rsp_status,
//                                             rsp_entries
//
// The whole chain updates at the edge that accepts a request, each cell
// deciding only from its own key and its two neighbors, so a new request
// can enter in every cycle while req_stall is low.
// Reset clears the key count and both output slots; cell contents are left
// as they are, since only cells below the count are ever looked at.
// The output register plus a skid slot let one further word be accepted
// while a finished response is stalled; req_stall rises once the skid is
// occupied.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_func,
   input  wire signed [KEY_WIDTH-1:0]             req_key_in,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic signed [KEY_WIDTH-1:0]            rsp_key_out,
   output logic [mhpq_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entries
);
   import mhpq_pkg::*;

   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   // Key count; the cells below it hold the keys sorted largest first.
   logic [CNT_WIDTH-1:0] count_ff;
   logic [CNT_WIDTH-1:0] count_in;

   // Output register and skid slot.
   logic                        rsp_valid_ff,  rsp_valid_in;
   logic signed [KEY_WIDTH-1:0] rsp_key_ff,    rsp_key_in;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff, rsp_status_in;
   logic [CNT_WIDTH-1:0]        rsp_cnt_ff,    rsp_cnt_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic signed [KEY_WIDTH-1:0] skid_key_ff,   skid_key_in;
   logic [STATUS_WIDTH-1:0]     skid_status_ff, skid_status_in;
   logic [CNT_WIDTH-1:0]        skid_cnt_ff,   skid_cnt_in;

   logic                        accept;
   logic                        full;
   logic                        empty;
   mhpq_ctrl_type               ctrl;
   logic signed [KEY_WIDTH-1:0] res_key;
   logic [STATUS_WIDTH-1:0]     res_status;

   logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];
   logic                        cell_stays [CAPACITY];

   // A word is taken whenever the skid slot is free.
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   assign full  = count_ff == CNT_WIDTH'(CAPACITY);
   assign empty = count_ff == '0;

   // Refused operations leave the chain and the count untouched.
   assign ctrl.insert  = accept && (req_func == FUNC_INSERT) && !full;
   assign ctrl.extract = accept && (req_func == FUNC_EXTRACT) && !empty;

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.extract) begin
         count_in = count_ff - 1'b1;
      end
   end

   // The largest key always sits in the first cell.
   always_comb begin
      res_key    = '0;
      res_status = ST_OK;
      if (req_func == FUNC_INSERT) begin
         if (full) begin
            res_status = ST_FULL;
         end
      end else begin
         if (empty) begin
            res_status = ST_EMPTY;
         end else begin
            res_key = cell_key[0];
         end
      end
   end

   // The first cell sees a left neighbor that never keeps its place and
   // offers the new key; the last cell shifts in its own key on extract.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_WIDTH-1:0] left_key;
      logic                        left_stays;
      logic signed [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_key   = req_key_in;
         assign left_stays = 1'b0;
      end else begin : g_inner
         assign left_key   = cell_key[i-1];
         assign left_stays = cell_stays[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      mhpq_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .CNT_WIDTH (CNT_WIDTH),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_key    (req_key_in),
         .count      (count_ff),
         .left_key   (left_key),
         .left_stays (left_stays),
         .right_key  (right_key),
         .key        (cell_key[i]),
         .stays      (cell_stays[i])
      );
   end

   // A new result goes to the output register when that register is free or
   // being emptied, and to the skid slot otherwise. A waiting skid word
   // moves forward as soon as the output is taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      skid_valid_in  = skid_valid_ff;
      skid_key_in    = skid_key_ff;
      skid_status_in = skid_status_ff;
      skid_cnt_in    = skid_cnt_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_valid_in  = 1'b1;
            rsp_key_in    = skid_key_ff;
            rsp_status_in = skid_status_ff;
            rsp_cnt_in    = skid_cnt_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_in  = 1'b1;
            rsp_key_in    = res_key;
            rsp_status_in = res_status;
            rsp_cnt_in    = count_in;
         end else begin
            skid_valid_in  = 1'b1;
            skid_key_in    = res_key;
            skid_status_in = res_status;
            skid_cnt_in    = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_key_ff     <= rsp_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      skid_key_ff    <= skid_key_in;
      skid_status_ff <= skid_status_in;
      skid_cnt_ff    <= skid_cnt_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_entries = rsp_cnt_ff;

endmodule
`default_nettype wire

// ===== sv/mhpq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_checker: port-level checks of the max-heap priority queue
// Watches the response channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_stall,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire signed [KEY_WIDTH-1:0]          rsp_key_out,
   input wire [mhpq_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input wire [$clog2(CAPACITY+1)-1:0]        rsp_entries
);
   import mhpq_pkg::*;

   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out) &&
         $stable(rsp_status) && $stable(rsp_entries))
      else $error("stalled response changed");

   // A refused extract reports an empty queue and a zero key.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entries == '0 && rsp_key_out == '0)
      else $error("empty status with keys held or nonzero key");

   // A refused insert reports a full queue and a zero key.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |->
         rsp_entries == CNT_WIDTH'(CAPACITY) && rsp_key_out == '0)
      else $error("full status below capacity or nonzero key");

   // Reset empties both output slots.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output slots not cleared by reset");

endmodule

bind max_heap_priority_queue mhpq_checker #(
   .CAPACITY  (CAPACITY),
   .KEY_WIDTH (KEY_WIDTH)
) u_mhpq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_key_out (rsp_key_out),
   .rsp_status  (rsp_status),
   .rsp_entries (rsp_entries)
);
`default_nettype wire

// ===== dv/mhpq_result_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_result_monitor: response checking for the max-heap priority queue
// Watches both channels of the block. Each accepted request is applied to a
// private heap image to predict its response, and each accepted response is
// compared against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module mhpq_result_monitor #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  wire                                 req_func,
   input  wire signed [KEY_WIDTH-1:0]          req_key_in,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  wire signed [KEY_WIDTH-1:0]          rsp_key_out,
   input  wire [mhpq_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input  wire [$clog2(CAPACITY+1)-1:0]        rsp_entries,
   output int                                  mismatch_count,
   output int                                  responses_owed
);
   import mhpq_pkg::*;

   localparam int ENTRY_WIDTH = $clog2(CAPACITY+1);

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [STATUS_WIDTH-1:0] status;
      logic [ENTRY_WIDTH-1:0]  entries;
   } heap_response_type;

   logic signed [KEY_WIDTH-1:0] heap_slots [CAPACITY];
   int                          key_count;
   heap_response_type           owed_responses [$];
   int                          errors;
   int                          owed;

   assign mismatch_count = errors;
   assign responses_owed = owed;

   initial begin
      errors    = 0;
      owed      = 0;
      key_count = 0;
   end

   // Applies one operation to the heap image and returns the response it
   // should produce. Only slots below key_count are ever read.
   function automatic heap_response_type apply_heap_op(input logic func,
                                                        input logic signed [KEY_WIDTH-1:0] key);
      heap_response_type           res;
      int                          pos;
      int                          parent;
      int                          left;
      int                          right;
      int                          best;
      logic signed [KEY_WIDTH-1:0] tmp;
      res.key    = '0;
      res.status = ST_OK;
      if (func == FUNC_INSERT) begin
         if (key_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            heap_slots[key_count] = key;
            pos = key_count;
            key_count++;
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (heap_slots[pos] <= heap_slots[parent]) break;
               tmp = heap_slots[pos];
               heap_slots[pos] = heap_slots[parent];
               heap_slots[parent] = tmp;
               pos = parent;
            end
         end
      end else begin
         if (key_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.key = heap_slots[0];
            key_count--;
            heap_slots[0] = heap_slots[key_count];
            pos = 0;
            while (pos < key_count) begin
               left  = 2 * pos + 1;
               right = left + 1;
               best  = pos;
               // The larger child wins; on a tie the left child is kept.
               if (left < key_count && heap_slots[left] > heap_slots[best]) best = left;
               if (right < key_count && heap_slots[right] > heap_slots[best]) best = right;
               if (best == pos) break;
               tmp = heap_slots[pos];
               heap_slots[pos] = heap_slots[best];
               heap_slots[best] = tmp;
               pos = best;
            end
         end
      end
      res.entries = ENTRY_WIDTH'(key_count);
      return res;
   endfunction

   always @(posedge clock) begin
      heap_response_type want;
      if (reset) begin
         key_count = 0;
         owed_responses.delete();
         owed = 0;
      end else begin
         // A response is always older than a request accepted at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (owed_responses.size() == 0) begin
               $error("unexpected response: key_out %0d, status %0d, entries %0d",
                      rsp_key_out, rsp_status, rsp_entries);
               errors++;
            end else begin
               want = owed_responses.pop_front();
               if (rsp_key_out !== want.key) begin
                  $error("rsp_key_out: expected %0d, got %0d",
                         $signed(want.key), rsp_key_out);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_entries !== want.entries) begin
                  $error("rsp_entries: expected %0d, got %0d", want.entries, rsp_entries);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_responses.insert(owed_responses.size(),
                                  apply_heap_op(req_func, req_key_in));
         end
         owed = owed_responses.size();
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the max-heap priority queue
// Drives insert and extract words into the queue, stalls the response side
// at random, and reports a verdict from the response monitor's error count.
// ----------------------------------------------------------------------------
module testbench;
   import mhpq_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int KEY_WIDTH    = 32;
   localparam int ENTRY_WIDTH  = $clog2(CAPACITY+1);
   localparam int RANDOM_WORDS = 680;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 24;
   // The slowest legal run is set by roughly 700 words, the longest sender gap
   // and receiver stall between them, and the two long holds. This limit
   // leaves several times that margin.
   localparam int CYCLE_LIMIT  = 300000;

   localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_valid  = 1'b0;
   logic                         req_func   = FUNC_INSERT;
   logic signed [KEY_WIDTH-1:0]  req_key_in = '0;
   logic                         rsp_stall  = 1'b0;
   wire                          req_stall;
   wire                          rsp_valid;
   wire signed [KEY_WIDTH-1:0]   rsp_key_out;
   wire [STATUS_WIDTH-1:0]       rsp_status;
   wire [ENTRY_WIDTH-1:0]        rsp_entries;
   int                           mismatch_count;
   int                           responses_owed;
   int                           cycle_count = 0;

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   max_heap_priority_queue #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_key_in  (req_key_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_key_out (rsp_key_out),
      .rsp_status  (rsp_status),
      .rsp_entries (rsp_entries)
   );

   mhpq_result_monitor #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) result_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_key_in     (req_key_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_key_out    (rsp_key_out),
      .rsp_status     (rsp_status),
      .rsp_entries    (rsp_entries),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed)
   );

   // Watchdog. A hung handshake or a response that never comes ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Idle length used by both sides: mostly none or a short one, now and
   // then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Key styles: full 32-bit random (covers every bit both ways), a narrow
   // band around zero that produces many equal keys, and the signed extremes
   // with their neighbors, zero and plus and minus one.
   function automatic logic signed [KEY_WIDTH-1:0] pick_key(input int style);
      case (style)
         2: begin
            return KEY_WIDTH'($urandom_range(0, 8)) - KEY_WIDTH'(4);
         end
         3: begin
            case ($urandom_range(0, 6))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return KEY_MIN + 1;
               3: return KEY_MAX - 1;
               4: return '0;
               5: return '1;
               default: return KEY_WIDTH'(1);
            endcase
         end
         default: begin
            return KEY_WIDTH'($urandom());
         end
      endcase
   endfunction

   // Offers one word and returns at the edge that accepts it. The valid line
   // is dropped only when a gap precedes the word, so back-to-back words keep
   // it high without a second assignment in the same time step. The payload
   // is held steady for as long as the word is stalled.
   task automatic send_word(input logic func, input logic signed [KEY_WIDTH-1:0] key,
                            input bit no_idle);
      int gap;
      gap = no_idle ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_key_in <= key;
      do @(posedge clock); while (req_stall);
   endtask

   // Response side. Free-flowing stretches alternate with random stalls. Twice
   // in the run the receiver holds off for a long stretch while the sender
   // keeps offering words, so the output slots fill and the block pushes
   // back on its request side.
   initial begin : receiver
      int run_len;
      int stall_len;
      int rx_cycles;
      int next_hold;
      int holds_done;
      rx_cycles  = 0;
      next_hold  = 300;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         stall_len = idle_length();
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rx_cycles += run_len + stall_len;
         if (holds_done < 2 && rx_cycles >= next_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_cycles += HOLD_CYCLES;
            next_hold  = rx_cycles + 1500;
            holds_done++;
         end
      end
   end

   // Request side: a short directed opening, then random phases.
   initial begin : sender
      int sent;
      int phase_len;
      int insert_pct;
      int key_style;
      int roll;
      bit no_idle;
      logic func;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Extract from an empty queue, then the signed extremes, equal keys and
      // alternating bit patterns, drained until the queue is empty again and
      // once more past empty.
      send_word(FUNC_EXTRACT, KEY_MAX, 1'b0);
      send_word(FUNC_INSERT, '0, 1'b0);
      send_word(FUNC_INSERT, KEY_MIN, 1'b0);
      send_word(FUNC_INSERT, KEY_MAX, 1'b0);
      send_word(FUNC_INSERT, '1, 1'b0);
      send_word(FUNC_INSERT, KEY_WIDTH'(1), 1'b0);
      send_word(FUNC_INSERT, KEY_MAX, 1'b0);
      send_word(FUNC_INSERT, KEY_MIN, 1'b0);
      send_word(FUNC_INSERT, KEY_WIDTH'(32'h5555_5555), 1'b0);
      send_word(FUNC_INSERT, KEY_WIDTH'(32'hAAAA_AAAA), 1'b0);
      repeat (10) send_word(FUNC_EXTRACT, KEY_WIDTH'($urandom()), 1'b0);
      // A lone key: its extract leaves the queue empty.
      send_word(FUNC_INSERT, KEY_WIDTH'(5), 1'b0);
      send_word(FUNC_EXTRACT, '0, 1'b0);

      // Random phases. Insert-heavy phases run the queue up to capacity and
      // past it, extract-heavy ones drain it to empty and below, balanced ones
      // keep it shuffling in the middle. Some phases send without any gaps.
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         phase_len  = $urandom_range(20, 90);
         roll       = $urandom_range(0, 9);
         insert_pct = (roll < 4) ? 92 : (roll < 7) ? 50 : 10;
         key_style  = $urandom_range(0, 3);
         no_idle    = ($urandom_range(0, 4) == 0);
         repeat (phase_len) begin
            func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
            send_word(func, pick_key(key_style), no_idle);
            sent++;
         end
      end
      req_valid <= 1'b0;

      // Wait for every owed response, sampled away from the active edge, then
      // give the block time to show any stray response.
      do @(negedge clock); while (responses_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
